[rtl/core/rbp_pkg.sv]
// shared types and constants for the radar blip projector
package rbp_pkg;

	// item operation codes
	typedef enum logic [1:0] {
		OP_FRAME  = 2'd0,
		OP_POSE   = 2'd1,
		OP_OBJECT = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	// height classes
	localparam logic [1:0] HC_LEVEL = 2'd0;
	localparam logic [1:0] HC_ABOVE = 2'd1;
	localparam logic [1:0] HC_BELOW = 2'd2;

	// register indexes on the apb port
	localparam logic [2:0] REG_ENABLED  = 3'd0;
	localparam logic [2:0] REG_RANGE    = 3'd1;
	localparam logic [2:0] REG_SCALE    = 3'd2;
	localparam logic [2:0] REG_CENTER_X = 3'd3;
	localparam logic [2:0] REG_CENTER_Y = 3'd4;
	localparam logic [2:0] REG_BAND     = 3'd5;

	localparam int ADDR_W = 5;

	// pose store layout
	localparam int          POSE_DEPTH = 15;
	localparam logic [3:0]  POSE_LAST  = 4'd14;
	localparam int          POSE_T     = 9;
	localparam int          POSE_OBS   = 12;

	// back end sequencer steps
	localparam logic [4:0] ST_CHECK   = 5'd0;
	localparam logic [4:0] ST_SQ0     = 5'd1;
	localparam logic [4:0] ST_SQ1     = 5'd2;
	localparam logic [4:0] ST_SQ2     = 5'd3;
	localparam logic [4:0] ST_RR      = 5'd4;
	localparam logic [4:0] ST_CMP     = 5'd5;
	localparam logic [4:0] ST_XF_LAST = 5'd13;
	localparam logic [4:0] ST_XF_END  = 5'd14;
	localparam logic [4:0] ST_CLAMP   = 5'd15;
	localparam logic [4:0] ST_HX      = 5'd16;
	localparam logic [4:0] ST_LX      = 5'd17;
	localparam logic [4:0] ST_HZ      = 5'd18;
	localparam logic [4:0] ST_LZ      = 5'd19;
	localparam logic [4:0] ST_ZEND    = 5'd20;
	localparam logic [4:0] ST_FINAL   = 5'd21;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_RUN,
		BK_OUT
	} bk_state_t;

	// configuration registers as seen by the datapath
	typedef struct packed {
		logic               enabled;
		logic [15:0]        range_world;
		logic [15:0]        display_scale;
		logic signed [15:0] center_x;
		logic signed [15:0] center_y;
		logic [30:0]        height_band;
	} cfg_t;

	// queue entry from front to back
	typedef struct packed {
		op_t         op;
		logic [3:0]  idx;
		logic [31:0] val;
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] pz;
	} q_item_t;

endpackage

[rtl/core/rbp_if.sv]
// item channel interfaces for objects in and blips out
interface rbp_obj_if;
	logic               valid;
	logic               ready;
	logic [1:0]         operation;
	logic [3:0]         coef_index;
	logic signed [31:0] coef_value;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic               is_enemy;
	logic               is_visible;

	modport source (output valid, operation, coef_index, coef_value, pos_x, pos_y, pos_z,
		is_enemy, is_visible, input ready);
	modport sink (input valid, operation, coef_index, coef_value, pos_x, pos_y, pos_z,
		is_enemy, is_visible, output ready);
endinterface

interface rbp_blip_if;
	logic               valid;
	logic               ready;
	logic [5:0]         blip_index;
	logic signed [15:0] blip_x;
	logic signed [15:0] blip_y;
	logic [1:0]         height_class;

	modport source (output valid, blip_index, blip_x, blip_y, height_class, input ready);
	modport sink (input valid, blip_index, blip_x, blip_y, height_class, output ready);
endinterface

[rtl/core/rbp_front.sv]
// front end: accepts items, drops those with no effect, queues the rest
module rbp_front (
	input  logic            clk,
	input  logic            arst_n,
	rbp_obj_if.sink         obj,
	input  rbp_pkg::cfg_t   cfg,
	output rbp_pkg::q_item_t q_item,
	output logic            q_valid,
	input  logic            q_pop
);

	rbp_pkg::q_item_t mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       fill_q;
	logic             take;
	logic             keep;
	logic             push;
	rbp_pkg::q_item_t new_item;

	assign obj.ready = (fill_q != 2'd2);
	assign take      = obj.valid && obj.ready;
	assign push      = take && keep;

	// classify the incoming item
	always_comb begin
		keep = 1'b0;
		unique case (rbp_pkg::op_t'(obj.operation))
			rbp_pkg::OP_FRAME:  keep = 1'b1;
			rbp_pkg::OP_POSE:   keep = (obj.coef_index <= rbp_pkg::POSE_LAST);
			rbp_pkg::OP_OBJECT: keep = cfg.enabled && obj.is_enemy && obj.is_visible;
			rbp_pkg::OP_NONE:   keep = 1'b0;
			default:            keep = 1'b0;
		endcase
	end

	always_comb begin
		new_item.op  = rbp_pkg::op_t'(obj.operation);
		new_item.idx = obj.coef_index;
		new_item.val = obj.coef_value;
		new_item.px  = obj.pos_x;
		new_item.py  = obj.pos_y;
		new_item.pz  = obj.pos_z;
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= new_item;
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (q_pop) rd_ptr_q <= !rd_ptr_q;
			fill_q <= fill_q + 2'(push) - 2'(q_pop);
		end
	end

	assign q_valid = (fill_q != 2'd0);
	assign q_item  = mem_q[rd_ptr_q];

endmodule

[rtl/core/rbp_back.sv]
// back end: pose store, range test, transform and display mapping on one multiplier
module rbp_back #(
	parameter int MAX_BLIPS = 64,
	parameter int CW        = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  rbp_pkg::cfg_t    cfg,
	input  rbp_pkg::q_item_t q_item,
	input  logic             q_valid,
	output logic             q_pop,
	rbp_blip_if.source       blip
);

	localparam logic signed [49:0] LIM = 50'sd1 <<< 46;

	logic [31:0]          pose_q [rbp_pkg::POSE_DEPTH];
	rbp_pkg::bk_state_t   state_q, state_d;
	logic [4:0]           step_q;
	logic [CW-1:0]        count_q;
	logic signed [31:0]   p_q [3];
	logic [23:0]          a_q [3];
	logic [49:0]          sum_q;
	logic signed [49:0]   acc_q [3];
	logic [1:0]           r_q, c_q, cc_q;
	logic signed [47:0]   vx_q, vz_q;
	logic signed [40:0]   pxa_q, pza_q;
	logic signed [15:0]   bx_q, by_q;
	logic [1:0]           hc_q;
	logic signed [63:0]   mul_q;
	logic                 ov_q;
	logic [5:0]           oidx_q;
	logic signed [15:0]   ox_q, oy_q;
	logic [1:0]           oh_q;

	logic                 start_obj;
	logic                 range_fail;
	logic                 sum_fail;
	logic                 out_load;
	logic [23:0]          r8;
	logic signed [32:0]   d [3];
	logic [32:0]          ad [3];
	logic signed [32:0]   op_a, op_b;
	logic [3:0]           m_idx;
	logic signed [49:0]   band_s;
	logic signed [41:0]   fx, fy;
	logic [40:0]          rnd;

	assign r8     = {cfg.range_world, 8'd0};
	assign m_idx  = 4'({r_q, 1'b0}) + 4'(r_q) + 4'(c_q);
	assign band_s = $signed({19'd0, cfg.height_band});
	assign rnd    = (mul_q[40:0] + 41'(24'h800000)) >> 24;

	assign start_obj = q_valid && (q_item.op == rbp_pkg::OP_OBJECT)
		&& (count_q < CW'(MAX_BLIPS));

	// distance per axis against the range
	always_comb begin
		range_fail = 1'b0;
		for (int i = 0; i < 3; i++) begin
			d[i]  = 33'(p_q[i]) - 33'($signed(pose_q[rbp_pkg::POSE_OBS + i]));
			ad[i] = d[i][32] ? 33'(-d[i]) : 33'(d[i]);
			if (ad[i] > {9'd0, r8}) range_fail = 1'b1;
		end
	end

	assign sum_fail = sum_q > {2'd0, mul_q[47:0]};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rbp_pkg::BK_IDLE: if (start_obj) state_d = rbp_pkg::BK_RUN;
			rbp_pkg::BK_RUN: begin
				if (step_q == rbp_pkg::ST_CHECK && range_fail) state_d = rbp_pkg::BK_IDLE;
				else if (step_q == rbp_pkg::ST_CMP && sum_fail) state_d = rbp_pkg::BK_IDLE;
				else if (step_q == rbp_pkg::ST_FINAL) state_d = rbp_pkg::BK_OUT;
			end
			rbp_pkg::BK_OUT: if (!ov_q || blip.ready) state_d = rbp_pkg::BK_IDLE;
			default: state_d = rbp_pkg::BK_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		q_pop    = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			rbp_pkg::BK_IDLE: q_pop = q_valid;
			rbp_pkg::BK_RUN:  q_pop = 1'b0;
			rbp_pkg::BK_OUT:  out_load = !ov_q || blip.ready;
			default:          q_pop = 1'b0;
		endcase
	end

	// multiplier operand select
	always_comb begin
		case (step_q)
			rbp_pkg::ST_SQ0: begin op_a = $signed({9'd0, a_q[0]}); op_b = op_a; end
			rbp_pkg::ST_SQ1: begin op_a = $signed({9'd0, a_q[1]}); op_b = op_a; end
			rbp_pkg::ST_SQ2: begin op_a = $signed({9'd0, a_q[2]}); op_b = op_a; end
			rbp_pkg::ST_RR:  begin op_a = $signed({9'd0, r8}); op_b = op_a; end
			rbp_pkg::ST_HX: begin
				op_a = 33'($signed(vx_q[47:24]));
				op_b = $signed({17'd0, cfg.display_scale});
			end
			rbp_pkg::ST_LX: begin
				op_a = $signed({9'd0, vx_q[23:0]});
				op_b = $signed({17'd0, cfg.display_scale});
			end
			rbp_pkg::ST_HZ: begin
				op_a = 33'($signed(vz_q[47:24]));
				op_b = $signed({17'd0, cfg.display_scale});
			end
			rbp_pkg::ST_LZ: begin
				op_a = $signed({9'd0, vz_q[23:0]});
				op_b = $signed({17'd0, cfg.display_scale});
			end
			default: begin
				op_a = 33'(p_q[r_q]);
				op_b = 33'($signed(pose_q[m_idx]));
			end
		endcase
	end

	// final pixel sums
	assign fx = 42'(pxa_q) + 42'(cfg.center_x);
	assign fy = 42'(pza_q) + 42'(cfg.center_y);

	// pose store
	always_ff @(posedge clk) begin
		if (q_pop && q_item.op == rbp_pkg::OP_POSE) pose_q[q_item.idx] <= q_item.val;
	end

	// datapath registers
	always_ff @(posedge clk) begin
		mul_q <= 64'(op_a * op_b);
		cc_q  <= c_q;
		if (q_pop && start_obj) begin
			p_q[0] <= $signed(q_item.px);
			p_q[1] <= $signed(q_item.py);
			p_q[2] <= $signed(q_item.pz);
			r_q    <= 2'd0;
			c_q    <= 2'd0;
		end
		if (state_q == rbp_pkg::BK_RUN) begin
			case (step_q)
				rbp_pkg::ST_CHECK: begin
					for (int i = 0; i < 3; i++) begin
						a_q[i]   <= ad[i][23:0];
						acc_q[i] <= 50'($signed(pose_q[rbp_pkg::POSE_T + i]));
					end
					sum_q <= '0;
				end
				rbp_pkg::ST_SQ1, rbp_pkg::ST_SQ2, rbp_pkg::ST_RR:
					sum_q <= sum_q + {2'd0, mul_q[47:0]};
				rbp_pkg::ST_CLAMP: begin
					if (acc_q[0] > LIM) vx_q <= 48'(LIM);
					else if (acc_q[0] < -LIM) vx_q <= 48'(-LIM);
					else vx_q <= 48'(acc_q[0]);
					if (acc_q[2] > LIM) vz_q <= 48'(LIM);
					else if (acc_q[2] < -LIM) vz_q <= 48'(-LIM);
					else vz_q <= 48'(acc_q[2]);
				end
				rbp_pkg::ST_LX: pxa_q <= mul_q[40:0];
				rbp_pkg::ST_HZ: pxa_q <= pxa_q + $signed(rnd);
				rbp_pkg::ST_LZ: pza_q <= mul_q[40:0];
				rbp_pkg::ST_ZEND: pza_q <= pza_q + $signed(rnd);
				rbp_pkg::ST_FINAL: begin
					if (fx > 42'sd32767) bx_q <= 16'sh7FFF;
					else if (fx < -42'sd32768) bx_q <= 16'sh8000;
					else bx_q <= fx[15:0];
					if (fy > 42'sd32767) by_q <= 16'sh7FFF;
					else if (fy < -42'sd32768) by_q <= 16'sh8000;
					else by_q <= fy[15:0];
					if (acc_q[1] > band_s) hc_q <= rbp_pkg::HC_ABOVE;
					else if (acc_q[1] < -band_s) hc_q <= rbp_pkg::HC_BELOW;
					else hc_q <= rbp_pkg::HC_LEVEL;
				end
				default: ;
			endcase
			// transform issue walks rows within each column
			if (step_q >= rbp_pkg::ST_CMP && step_q <= rbp_pkg::ST_XF_LAST) begin
				if (r_q == 2'd2) begin
					r_q <= 2'd0;
					c_q <= c_q + 2'd1;
				end else begin
					r_q <= r_q + 2'd1;
				end
			end
			// floored products are accumulated in the step after their issue
			if (step_q > rbp_pkg::ST_CMP && step_q <= rbp_pkg::ST_XF_END)
				acc_q[cc_q] <= acc_q[cc_q] + 50'(mul_q >>> 16);
		end
		if (out_load) begin
			oidx_q <= 6'(count_q);
			ox_q   <= bx_q;
			oy_q   <= by_q;
			oh_q   <= hc_q;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rbp_pkg::BK_IDLE;
			step_q  <= '0;
			count_q <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == rbp_pkg::BK_RUN) step_q <= step_q + 5'd1;
			else step_q <= rbp_pkg::ST_CHECK;
			if (q_pop && q_item.op == rbp_pkg::OP_FRAME) count_q <= '0;
			else if (out_load) count_q <= count_q + CW'(1);
			if (out_load) ov_q <= 1'b1;
			else if (blip.ready) ov_q <= 1'b0;
		end
	end

	assign blip.valid        = ov_q;
	assign blip.blip_index   = oidx_q;
	assign blip.blip_x       = ox_q;
	assign blip.blip_y       = oy_q;
	assign blip.height_class = oh_q;

endmodule

[rtl/core/radar_blip_projector_core.sv]
// top level of the radar blip projector with its apb register file
// An object item that passes the enemy, visible and enabled test is picked from the queue,
// then runs 22 sequencer steps that share a single 33x33 multiplier for three squared
// distances, the squared range, nine transform products and four display-scale products,
// then hands the blip to the output register. Frame and pose items are taken from the queue
// while idle, and filtered objects never reach the back end. A two-entry queue lets the
// front accept items while the back end works, and the output register lets the back end
// start the next item while a blip waits. Configuration goes through the apb port, register
// i at byte address 4*i; it must be written only while idle, not enforced by the block.
module radar_blip_projector_core #(
	parameter int MAX_BLIPS = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	rbp_obj_if.sink                    obj,
	rbp_blip_if.source                 blip,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rbp_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	localparam int CW = $clog2(MAX_BLIPS + 1);

	rbp_pkg::cfg_t    cfg_q;
	rbp_pkg::q_item_t q_item;
	logic             q_valid;
	logic             q_pop;
	logic             wr_en;
	logic [2:0]       reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_sel = paddr[4:2];

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled       <= 1'b1;
			cfg_q.range_world   <= 16'd15000;
			cfg_q.display_scale <= 16'd524;
			cfg_q.center_x      <= -16'sd512;
			cfg_q.center_y      <= -16'sd232;
			cfg_q.height_band   <= 31'd2560;
		end else if (wr_en) begin
			unique case (reg_sel)
				rbp_pkg::REG_ENABLED:  cfg_q.enabled       <= pwdata[0];
				rbp_pkg::REG_RANGE:    cfg_q.range_world   <= pwdata[15:0];
				rbp_pkg::REG_SCALE:    cfg_q.display_scale <= pwdata[15:0];
				rbp_pkg::REG_CENTER_X: cfg_q.center_x      <= pwdata[15:0];
				rbp_pkg::REG_CENTER_Y: cfg_q.center_y      <= pwdata[15:0];
				rbp_pkg::REG_BAND:     cfg_q.height_band   <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		unique case (reg_sel)
			rbp_pkg::REG_ENABLED:  prdata = {31'd0, cfg_q.enabled};
			rbp_pkg::REG_RANGE:    prdata = {16'd0, cfg_q.range_world};
			rbp_pkg::REG_SCALE:    prdata = {16'd0, cfg_q.display_scale};
			rbp_pkg::REG_CENTER_X: prdata = {16'd0, cfg_q.center_x};
			rbp_pkg::REG_CENTER_Y: prdata = {16'd0, cfg_q.center_y};
			rbp_pkg::REG_BAND:     prdata = {1'b0, cfg_q.height_band};
			default:               prdata = '0;
		endcase
	end

	rbp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.obj     (obj),
		.cfg     (cfg_q),
		.q_item  (q_item),
		.q_valid (q_valid),
		.q_pop   (q_pop)
	);

	rbp_back #(
		.MAX_BLIPS (MAX_BLIPS),
		.CW        (CW)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_item  (q_item),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.blip    (blip)
	);

endmodule

[rtl/core/rbp_checker.sv]
// port checker for the radar blip projector, bound to the top level
module rbp_checker #(
	parameter int MAX_BLIPS = 64
) (
	input logic        clk,
	input logic        arst_n,
	input logic        blip_valid,
	input logic        blip_ready,
	input logic [5:0]  blip_index,
	input logic [15:0] blip_x,
	input logic [1:0]  height_class,
	input logic        pready
);

	// a waiting blip stays
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		blip_valid && !blip_ready |=> blip_valid)
		else $error("blip dropped while stalled");

	// a waiting blip keeps its position
	a_hold_x: assert property (@(posedge clk) disable iff (!arst_n)
		blip_valid && !blip_ready |=> $stable(blip_x))
		else $error("blip x changed while stalled");

	// ordinal stays below the per frame limit
	a_index: assert property (@(posedge clk) disable iff (!arst_n)
		blip_valid |-> 32'(blip_index) < MAX_BLIPS)
		else $error("blip index beyond limit");

	// no unused height class
	a_class: assert property (@(posedge clk) disable iff (!arst_n)
		blip_valid |-> height_class != 2'd3)
		else $error("bad height class");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind radar_blip_projector_core rbp_checker #(.MAX_BLIPS(MAX_BLIPS)) u_rbp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.blip_valid   (blip.valid),
	.blip_ready   (blip.ready),
	.blip_index   (blip.blip_index),
	.blip_x       (blip.blip_x),
	.height_class (blip.height_class),
	.pready       (pready)
);
